// ===== design/gptk_pkg.sv =====
// Shared types, constants and scaling helpers for the gamepad report decoder.
// Used by every module of gamepad_report_to_key_events. No dependencies.
package gptk_pkg;

   // Flag vector and event limits
   localparam int NUM_FLAGS    = 18;
   localparam int FLAG_IDX_W   = $clog2(NUM_FLAGS);
   localparam int MAX_EVENTS   = 16;
   localparam int COUNT_W      = $clog2(MAX_EVENTS);
   localparam int KEY_ID_W     = 5;

   // Default depth of the queue between decoder and event serializer
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Input op codes
   localparam logic [1:0] OP_REPORT     = 2'd0;
   localparam logic [1:0] OP_CONNECT    = 2'd1;
   localparam logic [1:0] OP_DISCONNECT = 2'd2;

   // Register indexes on the csr port
   localparam logic CSR_STICK_THRESHOLD   = 1'b0;
   localparam logic CSR_TRIGGER_THRESHOLD = 1'b1;

   // Register reset values
   localparam logic [6:0]  STICK_THRESHOLD_RESET   = 7'd50;
   localparam logic [15:0] TRIGGER_THRESHOLD_RESET = 16'd250;

   // Physical key id of each flag position
   localparam logic [KEY_ID_W-1:0] KEY_IDS [NUM_FLAGS] = '{
      5'd1, 5'd2, 5'd3, 5'd4, 5'd25, 5'd26, 5'd27, 5'd28, 5'd5,
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14
   };

   // Kind of work handed from the decoder to the serializer
   typedef enum logic [1:0] {
      KIND_REPORT     = 2'd0,
      KIND_CONNECT    = 2'd1,
      KIND_DISCONNECT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [NUM_FLAGS-1:0]   flags;
   } entry_type;

   // 16-bit axis to -100..99, truncating toward zero
   function automatic logic signed [8:0] scale16(input logic [15:0] raw);
      logic signed [16:0] v;
      logic signed [23:0] p;
      logic signed [23:0] r;
      v = $signed({1'b0, raw}) - 17'sd32768;
      p = 24'(v) * 24'sd100;
      r = p + (p[23] ? 24'sd32767 : 24'sd0);
      return $signed(r[23:15]);
   endfunction

   // 8-bit axis to -100..99, truncating toward zero
   function automatic logic signed [8:0] scale8(input logic [7:0] raw);
      logic signed [8:0]  v;
      logic signed [15:0] p;
      logic signed [15:0] r;
      v = $signed({1'b0, raw}) - 9'sd128;
      p = 16'(v) * 16'sd100;
      r = p + (p[15] ? 16'sd127 : 16'sd0);
      return $signed(r[15:7]);
   endfunction

   // Hat position to direction bits: bit0 up, bit1 down, bit2 left, bit3 right
   function automatic logic [3:0] hat_dirs(input logic [7:0] hat);
      logic [3:0] d;
      case (hat)
         8'd1:    d = 4'd1;
         8'd2:    d = 4'd9;
         8'd3:    d = 4'd8;
         8'd4:    d = 4'd10;
         8'd5:    d = 4'd2;
         8'd6:    d = 4'd6;
         8'd7:    d = 4'd4;
         8'd8:    d = 4'd5;
         default: d = 4'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== design/gamepad_report_to_key_events.sv =====
// Top level of the gamepad report to key event converter.
// Depends on gptk_pkg, gptk_front, gptk_fifo and gptk_back.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_ready  | op, 15 report bytes, report length
//   rsp     | out       | rsp_valid/rsp_ready  | key id, pressed, last, link up
//   csr     | in        | csr_wr_en            | register index and write data
//
// The front end takes one request per cycle while req_ready is high and decodes it
// into a staging register. The serializer takes an entry from the queue while idle
// and then sends one event per changed key, k = 0..16 events, while rsp is not stalled.
// Reset is synchronous; it clears the stored keys, the link flag and the queue.
// A stalled rsp side fills the queue before req_ready drops.
module gamepad_report_to_key_events import gptk_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [63:0]         req_report_low,
   input  logic [55:0]         req_report_high,
   input  logic [15:0]         req_report_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KEY_ID_W-1:0] rsp_key_id,
   output logic                rsp_pressed,
   output logic                rsp_last,
   output logic                rsp_link_up
);

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   gptk_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_report_low    (req_report_low),
      .req_report_high   (req_report_high),
      .req_report_length (req_report_length),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   gptk_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   gptk_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_key_id  (rsp_key_id),
      .rsp_pressed (rsp_pressed),
      .rsp_last    (rsp_last),
      .rsp_link_up (rsp_link_up)
   );

endmodule

// ===== design/gptk_front.sv =====
// Front end: csr registers, report decode into the 18 key flags, one staging register.
// Depends on gptk_pkg.
module gptk_front import gptk_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [63:0]      req_report_low,
   input  logic [55:0]      req_report_high,
   input  logic [15:0]      req_report_length,
   output logic             push_valid,
   input  logic             push_ready,
   output entry_type        push_entry
);

   localparam logic [15:0] LEN_MIN  = 16'd4;
   localparam logic [15:0] LEN_HAT  = 16'd5;
   localparam logic [15:0] LEN_BTN  = 16'd6;
   localparam logic [15:0] LEN_WIDE = 16'd15;

   logic [6:0]  stick_thr_ff,  stick_thr_in;
   logic [15:0] trig_thr_ff,   trig_thr_in;
   logic        stage_valid_ff, stage_valid_in;
   entry_type   stage_ff,       stage_in;

   logic        req_fire;
   logic        keep;
   logic [7:0]  b [15];
   logic [NUM_FLAGS-1:0] flags;

   // csr writes
   always_comb begin
      stick_thr_in = stick_thr_ff;
      trig_thr_in  = trig_thr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STICK_THRESHOLD:   stick_thr_in = csr_wdata[6:0];
            CSR_TRIGGER_THRESHOLD: trig_thr_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // report decode
   always_comb begin
      logic signed [8:0] lx, ly, rx, ry, tp, tn;
      logic [7:0] hat, btn;
      logic [3:0] dirs;
      logic a, bb, x, y, l1, r1, l2, r2, sel, st;
      for (int i = 0; i < 8; i++) b[i] = req_report_low[8*i +: 8];
      for (int i = 0; i < 7; i++) b[8+i] = req_report_high[8*i +: 8];
      dirs = 4'd0;
      {a, bb, x, y, l1, r1, l2, r2, sel, st} = '0;
      hat = 8'd0;
      btn = 8'd0;
      if (req_report_length >= LEN_WIDE) begin
         lx  = scale16({b[1], b[0]});
         ly  = scale16({b[3], b[2]});
         rx  = scale16({b[5], b[4]});
         ry  = scale16({b[7], b[6]});
         l2  = {b[9], b[8]} > trig_thr_ff;
         r2  = {b[11], b[10]} > trig_thr_ff;
         // hat falls back to byte 14, buttons fall back to byte 11
         hat = (b[12] <= 8'd8) ? b[12] : ((b[14] <= 8'd8) ? b[14] : 8'd0);
         dirs = hat_dirs(hat);
         btn = (b[13] != 8'd0 || b[12] <= 8'd8) ? b[13] : b[11];
         a   = btn[0];
         bb  = btn[1];
         x   = btn[3];
         y   = btn[4];
         l1  = btn[6];
         r1  = btn[7];
         sel = b[14][2];
         st  = b[14][3];
      end else begin
         lx = scale8(b[0]);
         ly = scale8(b[1]);
         rx = scale8(b[2]);
         ry = scale8(b[3]);
         if (req_report_length >= LEN_HAT) begin
            dirs = hat_dirs({4'd0, b[4][3:0]});
            {y, x, bb, a} = b[4][7:4];
         end
         if (req_report_length >= LEN_BTN) begin
            {st, sel, r2, l2, r1, l1} = b[5][5:0];
         end
      end
      // stick thresholds
      tp = $signed({2'b00, stick_thr_ff});
      tn = -tp;
      flags[0]  = dirs[0] | (ly < tn);
      flags[1]  = dirs[1] | (ly > tp);
      flags[2]  = dirs[2] | (lx < tn);
      flags[3]  = dirs[3] | (lx > tp);
      flags[4]  = ry < tn;
      flags[5]  = ry > tp;
      flags[6]  = rx < tn;
      flags[7]  = rx > tp;
      flags[8]  = a;
      flags[9]  = bb;
      flags[10] = x;
      flags[11] = y;
      flags[12] = r1;
      flags[13] = l1;
      flags[14] = r2;
      flags[15] = l2;
      flags[16] = st;
      flags[17] = sel;
   end

   // classify the beat; short reports and the unused op are dropped here
   always_comb begin
      keep           = 1'b0;
      stage_in       = stage_ff;
      stage_in.flags = flags;
      unique case (req_op)
         OP_REPORT: begin
            keep          = req_report_length >= LEN_MIN;
            stage_in.kind = KIND_REPORT;
         end
         OP_CONNECT: begin
            keep          = 1'b1;
            stage_in.kind = KIND_CONNECT;
         end
         OP_DISCONNECT: begin
            keep          = 1'b1;
            stage_in.kind = KIND_DISCONNECT;
         end
         default: begin
            keep          = 1'b0;
            stage_in.kind = KIND_REPORT;
         end
      endcase
   end

   assign req_ready  = !stage_valid_ff || push_ready;
   assign req_fire   = req_valid && req_ready;
   assign push_valid = stage_valid_ff;
   assign push_entry = stage_ff;

   // staging register
   always_comb begin
      stage_valid_in = stage_valid_ff && !push_ready;
      if (req_fire && keep) stage_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_thr_ff   <= STICK_THRESHOLD_RESET;
         trig_thr_ff    <= TRIGGER_THRESHOLD_RESET;
         stage_valid_ff <= 1'b0;
      end else begin
         stick_thr_ff   <= stick_thr_in;
         trig_thr_ff    <= trig_thr_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && keep) stage_ff <= stage_in;
   end

endmodule

// ===== design/gptk_fifo.sv =====
// Short queue of decoded entries between the front end and the serializer.
// Depends on gptk_pkg.
module gptk_fifo import gptk_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== design/gptk_back.sv =====
// Back end: stored key flags, link flag, and the event serializer with its output register.
// Depends on gptk_pkg.
module gptk_back import gptk_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  entry_type           pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KEY_ID_W-1:0] rsp_key_id,
   output logic                rsp_pressed,
   output logic                rsp_last,
   output logic                rsp_link_up
);

   logic [NUM_FLAGS-1:0] prev_ff, prev_in;
   logic [NUM_FLAGS-1:0] cur_ff,  cur_in;
   logic [NUM_FLAGS-1:0] pend_ff, pend_in;
   logic                 busy_ff, busy_in;
   logic                 link_ff, link_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 out_valid_ff, out_valid_in;
   logic [KEY_ID_W-1:0]  out_key_ff;
   logic                 out_pressed_ff, out_last_ff, out_link_ff;

   logic                  pop, emit, out_free, ev_last;
   logic [NUM_FLAGS-1:0]  low_bit, rest;
   logic [FLAG_IDX_W-1:0] low_idx;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign pop_ready = !busy_ff;
   assign pop       = pop_valid && pop_ready;
   assign emit      = busy_ff && out_free;

   // lowest pending flag
   always_comb begin
      low_bit = pend_ff & (~pend_ff + 1'b1);
      rest    = pend_ff & ~low_bit;
      low_idx = '0;
      for (int i = 0; i < NUM_FLAGS; i++) begin
         low_idx = low_idx | (low_bit[i] ? FLAG_IDX_W'(i) : '0);
      end
      ev_last = (rest == '0) || (count_ff == COUNT_W'(MAX_EVENTS - 1));
   end

   // take an entry, or send one event per cycle while the output register is free
   always_comb begin
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      pend_in  = pend_ff;
      busy_in  = busy_ff;
      link_in  = link_ff;
      count_in = count_ff;
      if (pop) begin
         unique case (pop_entry.kind)
            KIND_REPORT: begin
               link_in  = 1'b1;
               cur_in   = pop_entry.flags;
               pend_in  = pop_entry.flags ^ prev_ff;
               busy_in  = (pop_entry.flags ^ prev_ff) != '0;
               count_in = '0;
            end
            KIND_CONNECT: link_in = 1'b1;
            KIND_DISCONNECT: begin
               link_in = 1'b0;
               prev_in = '0;
            end
            default: ;
         endcase
      end else if (emit) begin
         prev_in  = (prev_ff & ~low_bit) | (cur_ff & low_bit);
         pend_in  = rest;
         count_in = count_ff + 1'b1;
         if (ev_last) busy_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         busy_ff      <= 1'b0;
         link_ff      <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         busy_ff      <= busy_in;
         link_ff      <= link_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
      if (emit) begin
         out_key_ff     <= KEY_IDS[low_idx];
         out_pressed_ff <= |(cur_ff & low_bit);
         out_last_ff    <= ev_last;
         out_link_ff    <= link_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_key_id  = out_key_ff;
   assign rsp_pressed = out_pressed_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_link_up = out_link_ff;

`ifndef SYNTHESIS
   // a busy serializer always has a change left to send
   a_busy_has_pending: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pend_ff != '0)
      else $error("serializer busy with no pending change");

   // the final event of a report frees the serializer
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (emit && ev_last) |=> !busy_ff)
      else $error("serializer still busy after final event");

   // a disconnect wipes the stored flags and the link
   a_disconnect_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_entry.kind == KIND_DISCONNECT) |=> (prev_ff == '0 && !link_ff))
      else $error("disconnect left state behind");

   // the stored flags only move toward the report being serialized
   a_prev_tracks_cur: assert property (@(posedge clock) disable iff (reset)
      emit |=> ((prev_ff ^ cur_ff) & $past(low_bit)) == '0)
      else $error("sent flag not recorded");
`endif

endmodule

// ===== verif/key_event_checker.sv =====
// Checker for gamepad_report_to_key_events: watches the csr, req and rsp ports, works out
// the key events each accepted request should cause, and compares them with the rsp beats.
// Depends on gptk_pkg for widths, op codes, register indexes and reset values.
`timescale 1ns / 100ps

module key_event_checker import gptk_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [63:0]         req_report_low,
   input  logic [55:0]         req_report_high,
   input  logic [15:0]         req_report_length,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [KEY_ID_W-1:0] rsp_key_id,
   input  logic                rsp_pressed,
   input  logic                rsp_last,
   input  logic                rsp_link_up,
   output int                  errors,
   output int                  pending
);

   localparam int FLAG_COUNT  = 18;
   localparam int EVENT_CAP   = 16;
   localparam int PRINT_LIMIT = 200;

   // key id per flag position: directions, right stick, buttons, start, select
   localparam logic [KEY_ID_W-1:0] FLAG_KEY_ID [FLAG_COUNT] = '{
      5'd1, 5'd2, 5'd3, 5'd4, 5'd25, 5'd26, 5'd27, 5'd28, 5'd5,
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14
   };

   // hat position to direction bits {right, left, down, up}
   localparam logic [3:0] HAT_TO_DIRS [9] = '{
      4'd0, 4'd1, 4'd9, 4'd8, 4'd10, 4'd2, 4'd6, 4'd4, 4'd5
   };

   typedef struct packed {
      logic [KEY_ID_W-1:0] key_id;
      logic                pressed;
      logic                last;
      logic                link_up;
   } key_event_type;

   key_event_type         expected_key_events [$];
   logic [FLAG_COUNT-1:0] held_keys;
   logic                  link_state;
   logic [6:0]            stick_thr;
   logic [15:0]           trig_thr;
   int                    fail_count = 0;
   int                    printed = 0;

   initial begin
      errors  = 0;
      pending = 0;
   end

   // axis scaling, division truncates toward zero
   function automatic int pct16(input logic [15:0] raw);
      int v;
      v = raw;
      return ((v - 32768) * 100) / 32768;
   endfunction

   function automatic int pct8(input logic [7:0] raw);
      int v;
      v = raw;
      return ((v - 128) * 100) / 128;
   endfunction

   function automatic logic [3:0] hat_to_dirs(input logic [7:0] hat);
      return (hat <= 8'd8) ? HAT_TO_DIRS[hat[3:0]] : 4'd0;
   endfunction

   // Decode one request beat, update the stored keys and queue the events it causes
   task automatic decode_report(input logic [1:0] op, input logic [63:0] lo,
                                input logic [55:0] hi, input logic [15:0] len);
      logic [7:0]            rb [15];
      logic [7:0]            hat, btn;
      logic [3:0]            dirs;
      logic [FLAG_COUNT-1:0] cur, nxt;
      logic                  a_k, b_k, x_k, y_k, l1_k, r1_k, l2_k, r2_k, sel_k, st_k;
      int                    lx, ly, rx, ry, thr, n;
      int                    changed [EVENT_CAP];
      key_event_type         ev;
      if (op == OP_CONNECT) begin
         link_state = 1'b1;
      end else if (op == OP_DISCONNECT) begin
         link_state = 1'b0;
         held_keys  = '0;
      end else if (op == OP_REPORT && len >= 16'd4) begin
         for (int i = 0; i < 8; i++) rb[i] = lo[8*i +: 8];
         for (int i = 0; i < 7; i++) rb[8+i] = hi[8*i +: 8];
         {a_k, b_k, x_k, y_k, l1_k, r1_k, l2_k, r2_k, sel_k, st_k} = '0;
         dirs = 4'd0;
         if (len >= 16'd15) begin
            // 16-bit layout
            lx   = pct16({rb[1], rb[0]});
            ly   = pct16({rb[3], rb[2]});
            rx   = pct16({rb[5], rb[4]});
            ry   = pct16({rb[7], rb[6]});
            l2_k = {rb[9], rb[8]} > trig_thr;
            r2_k = {rb[11], rb[10]} > trig_thr;
            // hat falls back to byte 14, buttons to byte 11
            hat  = (rb[12] <= 8'd8) ? rb[12] : ((rb[14] <= 8'd8) ? rb[14] : 8'd0);
            btn  = (rb[13] != 8'd0 || rb[12] <= 8'd8) ? rb[13] : rb[11];
            dirs = hat_to_dirs(hat);
            a_k  = btn[0];
            b_k  = btn[1];
            x_k  = btn[3];
            y_k  = btn[4];
            l1_k = btn[6];
            r1_k = btn[7];
            sel_k = rb[14][2];
            st_k  = rb[14][3];
         end else begin
            // 8-bit layout, optional hat/button bytes
            lx = pct8(rb[0]);
            ly = pct8(rb[1]);
            rx = pct8(rb[2]);
            ry = pct8(rb[3]);
            if (len >= 16'd5) begin
               dirs = hat_to_dirs({4'd0, rb[4][3:0]});
               {y_k, x_k, b_k, a_k} = rb[4][7:4];
            end
            if (len >= 16'd6) begin
               {st_k, sel_k, r2_k, l2_k, r1_k, l1_k} = rb[5][5:0];
            end
         end
         thr = int'(stick_thr);
         if (ly < -thr) dirs[0] = 1'b1;
         if (ly > thr)  dirs[1] = 1'b1;
         if (lx < -thr) dirs[2] = 1'b1;
         if (lx > thr)  dirs[3] = 1'b1;
         cur = {sel_k, st_k, l2_k, r2_k, l1_k, r1_k, y_k, x_k, b_k, a_k,
                rx > thr, rx < -thr, ry > thr, ry < -thr, dirs};
         link_state = 1'b1;
         // changes past the cap stay stored as before
         nxt = held_keys;
         n   = 0;
         for (int i = 0; i < FLAG_COUNT; i++) begin
            if (n < EVENT_CAP && cur[i] != held_keys[i]) begin
               changed[n] = i;
               nxt[i]     = cur[i];
               n++;
            end
         end
         held_keys = nxt;
         for (int k = 0; k < n; k++) begin
            ev.key_id  = FLAG_KEY_ID[changed[k]];
            ev.pressed = cur[changed[k]];
            ev.last    = (k == n - 1);
            ev.link_up = 1'b1;
            expected_key_events.push_back(ev);
         end
      end
   endtask

   // Compare one rsp beat with the oldest expected event
   task automatic check_key_event();
      key_event_type want;
      if (expected_key_events.size() == 0) begin
         fail_count++;
         if (printed < PRINT_LIMIT)
            $display({"%0t: unexpected key event: expected none, ",
                      "got id %0d pressed %0b last %0b link %0b"},
                     $time, rsp_key_id, rsp_pressed, rsp_last, rsp_link_up);
         printed++;
      end else begin
         want = expected_key_events.pop_front();
         if (want.key_id !== rsp_key_id || want.pressed !== rsp_pressed ||
             want.last !== rsp_last || want.link_up !== rsp_link_up) begin
            fail_count++;
            if (printed < PRINT_LIMIT)
               $display({"%0t: key event mismatch: ",
                         "expected id %0d pressed %0b last %0b link %0b, ",
                         "got id %0d pressed %0b last %0b link %0b"},
                        $time, want.key_id, want.pressed, want.last, want.link_up,
                        rsp_key_id, rsp_pressed, rsp_last, rsp_link_up);
            printed++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_keys  = '0;
         link_state = 1'b0;
         stick_thr  = STICK_THRESHOLD_RESET;
         trig_thr   = TRIGGER_THRESHOLD_RESET;
         expected_key_events.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_STICK_THRESHOLD) stick_thr = csr_wdata[6:0];
            else trig_thr = csr_wdata;
         end
         if (rsp_valid && rsp_ready) check_key_event();
         if (req_valid && req_ready)
            decode_report(req_op, req_report_low, req_report_high, req_report_length);
      end
      errors  <= fail_count;
      pending <= expected_key_events.size();
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top for gamepad_report_to_key_events: clock, reset, csr writes, request
// stimulus and rsp back-pressure. Checking lives in key_event_checker; depends on gptk_pkg.
`timescale 1ns / 100ps

module tb import gptk_pkg::*; ();

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RESET_CYCLES = 5;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_GUARD  = 32;   // staging register, queue and serializer emptied
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_BEATS  = 80;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic                csr_index;
   logic [15:0]         csr_wdata;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_op;
   logic [63:0]         req_report_low;
   logic [55:0]         req_report_high;
   logic [15:0]         req_report_length;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [KEY_ID_W-1:0] rsp_key_id;
   logic                rsp_pressed;
   logic                rsp_last;
   logic                rsp_link_up;
   int                  errors;
   int                  pending;
   bit                  gaps_on;
   bit                  stall_on;
   bit                  hold_rsp;
   logic [15:0]         trig_now;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   gamepad_report_to_key_events u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_report_low    (req_report_low),
      .req_report_high   (req_report_high),
      .req_report_length (req_report_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_id        (rsp_key_id),
      .rsp_pressed       (rsp_pressed),
      .rsp_last          (rsp_last),
      .rsp_link_up       (rsp_link_up)
   );

   key_event_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_report_low    (req_report_low),
      .req_report_high   (req_report_high),
      .req_report_length (req_report_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_id        (rsp_key_id),
      .rsp_pressed       (rsp_pressed),
      .rsp_last          (rsp_last),
      .rsp_link_up       (rsp_link_up),
      .errors            (errors),
      .pending           (pending)
   );

   // Report byte packing
   function automatic logic [63:0] axes16(input logic [15:0] lx, ly, rx, ry);
      return {ry, rx, ly, lx};
   endfunction

   function automatic logic [55:0] tail16(input logic [15:0] lt, rt,
                                          input logic [7:0] b12, b13, b14);
      return {b14, b13, b12, rt, lt};
   endfunction

   // Axis values: rails, near center, or anywhere
   function automatic logic [15:0] rand_axis16();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1:       return 16'(32768 + $urandom_range(0, 1200) - 600);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_axis8();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1:       return 8'(128 + $urandom_range(0, 10) - 5);
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_trigger();
      if ($urandom_range(0, 1)) return 16'(trig_now + $urandom_range(0, 4) - 2);
      return 16'($urandom);
   endfunction

   // Offer one request beat; returns at the falling edge after it is taken, valid still high
   task automatic offer_beat(input logic [1:0] op, input logic [63:0] lo,
                             input logic [55:0] hi, input logic [15:0] len);
      int gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_op            = op;
      req_report_low    = lo;
      req_report_high   = hi;
      req_report_length = len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == CSR_TRIGGER_THRESHOLD) trig_now = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Stop offering and wait until every expected event has come out
   task automatic wait_for_results();
      req_valid = 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   // Mostly well-formed reports with random content, some link ops and noise
   task automatic make_random_beat(output logic [1:0] op, output logic [63:0] lo,
                                   output logic [55:0] hi, output logic [15:0] len);
      int          pick;
      logic [15:0] rx16, ry16;
      logic [7:0]  b12, b13, b14, b4, b5;
      pick = $urandom_range(0, 99);
      op   = OP_REPORT;
      lo   = {$urandom, $urandom};
      hi   = 56'({$urandom, $urandom});
      len  = 16'd15;
      if (pick < 4) begin
         op = OP_CONNECT;
      end else if (pick < 8) begin
         op = OP_DISCONNECT;
      end else if (pick < 10) begin
         op = OP_UNUSED;
      end else if (pick < 14) begin
         len = 16'($urandom_range(0, 3));
      end else if (pick < 20) begin
         // everything held or everything released, right stick on a rail
         rx16 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         ry16 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         if ($urandom_range(0, 1)) begin
            lo = axes16(16'h0000, 16'hFFFF, rx16, ry16);
            hi = tail16(16'hFFFF, 16'hFFFF, 8'd2, 8'hFF, 8'h0C);
         end else begin
            lo = axes16(16'h8000, 16'h8000, rx16, ry16);
            hi = tail16(16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0);
         end
      end else if (pick < 62) begin
         b12 = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 255)) :
               8'($urandom_range(0, 8));
         b13 = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
         b14 = $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
         lo  = axes16(rand_axis16(), rand_axis16(), rand_axis16(), rand_axis16());
         hi  = tail16(rand_trigger(), rand_trigger(), b12, b13, b14);
         if ($urandom_range(0, 4) == 0) len = 16'($urandom_range(16, 65535));
      end else begin
         b4  = $urandom_range(0, 3) == 0 ? 8'($urandom) :
               {4'($urandom), 4'($urandom_range(0, 8))};
         b5  = 8'($urandom);
         lo  = {lo[63:48], b5, b4, rand_axis8(), rand_axis8(), rand_axis8(), rand_axis8()};
         len = 16'($urandom_range(4, 14));
      end
   endtask

   // Directed beats under the reset thresholds
   task automatic run_directed();
      // short reports, link ops
      offer_beat(OP_REPORT, 64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 16'd0);
      offer_beat(OP_REPORT, 64'h0, 56'h0, 16'd3);
      offer_beat(OP_CONNECT, 64'h0, 56'h0, 16'd0);
      offer_beat(OP_DISCONNECT, 64'h0, 56'h0, 16'd0);
      // 8-bit layout: centered, rails, hat/buttons, shoulder byte, ignored hat
      offer_beat(OP_REPORT, 64'h0000_0000_8080_8080, 56'h0, 16'd4);
      offer_beat(OP_REPORT, 64'h0000_0000_00FF_FF00, 56'h0, 16'd4);
      offer_beat(OP_REPORT, 64'h0000_00F8_8080_8080, 56'h0, 16'd5);
      offer_beat(OP_REPORT, 64'h0000_3F03_8080_8080, 56'h0, 16'd6);
      offer_beat(OP_REPORT, 64'hA5C3_0009_8080_8080, 56'h5A_5A5A_5A5A_5A5A, 16'd14);
      // 16-bit layout: everything held, then 18 changes so two wait for the next report
      offer_beat(OP_REPORT, axes16(16'h0000, 16'hFFFF, 16'h0000, 16'h0000),
                 tail16(16'hFFFF, 16'hFFFF, 8'd2, 8'hFF, 8'h0C), 16'd15);
      offer_beat(OP_REPORT, axes16(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF),
                 tail16(16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0), 16'd15);
      offer_beat(OP_REPORT, axes16(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF),
                 tail16(16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0), 16'd15);
      // hat taken from byte 14, buttons from byte 11
      offer_beat(OP_REPORT, axes16(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                 tail16(16'h0000, 16'hDB00, 8'hFF, 8'h00, 8'h04), 16'hFFFF);
      // neither hat byte usable
      offer_beat(OP_REPORT, axes16(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                 tail16(16'h0000, 16'h2400, 8'h10, 8'h00, 8'h0C), 16'd300);
      // nonzero byte 13 wins over byte 11
      offer_beat(OP_REPORT, axes16(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                 tail16(16'h0000, 16'h1100, 8'd9, 8'h80, 8'h10), 16'd15);
      // triggers on either side of the threshold
      offer_beat(OP_REPORT, axes16(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                 tail16(16'd250, 16'd251, 8'd0, 8'd0, 8'd0), 16'd15);
      offer_beat(OP_REPORT, axes16(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                 tail16(16'd251, 16'd250, 8'd0, 8'd0, 8'd0), 16'd15);
      // disconnect drops stored keys, the same report presses again
      offer_beat(OP_DISCONNECT, 64'h0, 56'h0, 16'd15);
      offer_beat(OP_REPORT, axes16(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                 tail16(16'd251, 16'd250, 8'd0, 8'd0, 8'd0), 16'd15);
      offer_beat(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 16'd15);
      offer_beat(OP_CONNECT, 64'h0, 56'h0, 16'd15);
   endtask

   // Receiver: random stall bursts, one long hold on request
   initial begin : rsp_sink
      int burst;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_ready = 1'b0;
            repeat (burst) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   // Watchdog: too long with no beat on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      logic [1:0]  op;
      logic [63:0] lo;
      logic [55:0] hi;
      logic [15:0] len;
      int          done;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_STICK_THRESHOLD;
      csr_wdata         = 16'd0;
      req_valid         = 1'b0;
      req_op            = OP_REPORT;
      req_report_low    = 64'd0;
      req_report_high   = 56'd0;
      req_report_length = 16'd0;
      gaps_on           = 1'b1;
      stall_on          = 1'b1;
      hold_rsp          = 1'b0;
      trig_now          = TRIGGER_THRESHOLD_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      run_directed();

      // random phases, thresholds changed while idle; the last phase runs without idling
      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            wait_for_results();
            repeat (DRAIN_GUARD) @(negedge clock);
            case (phase)
               1: begin
                  write_reg(CSR_STICK_THRESHOLD, 16'd0);
                  write_reg(CSR_TRIGGER_THRESHOLD, 16'd0);
               end
               2: begin
                  write_reg(CSR_STICK_THRESHOLD, 16'd100);
                  write_reg(CSR_TRIGGER_THRESHOLD, 16'hFFFF);
               end
               3: begin
                  write_reg(CSR_STICK_THRESHOLD, 16'd127);
                  write_reg(CSR_TRIGGER_THRESHOLD, 16'($urandom_range(1, 65534)));
               end
               default: begin
                  write_reg(CSR_STICK_THRESHOLD, 16'($urandom_range(1, 99)));
                  write_reg(CSR_TRIGGER_THRESHOLD, 16'($urandom_range(0, 2000)));
               end
            endcase
         end
         gaps_on  = (phase != 4);
         stall_on = (phase != 4);
         done = 0;
         while (done < PHASE_BEATS) begin
            make_random_beat(op, lo, hi, len);
            offer_beat(op, lo, hi, len);
            if (op == OP_CONNECT || op == OP_DISCONNECT ||
                (op == OP_REPORT && len >= 16'd4)) begin
               done++;
               // long receiver hold while requests keep coming
               if (phase == 1 && done == 30) hold_rsp = 1'b1;
               // sender pause until the block has drained
               if (phase == 2 && done == 40) wait_for_results();
            end
         end
      end

      wait_for_results();
      repeat (DRAIN_GUARD) @(negedge clock);
      if (errors == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/gptk_pkg.sv
design/gptk_front.sv
design/gptk_fifo.sv
design/gptk_back.sv
design/gamepad_report_to_key_events.sv
verif/key_event_checker.sv
verif/tb.sv
